### hdl/line_sensor_pd_steering_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line sensor steering block
// Shared property shapes; clocked, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_PD_STEERING_TOP_DEFINES_SVH
`define LINE_SENSOR_PD_STEERING_TOP_DEFINES_SVH

// cond must hold at every edge out of reset
`define LSPS_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
		else $error("assertion failed");

// ante at one edge forces cons at the next edge
`define LSPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg
// Constants, types and helpers shared by the steering block.
// ----------------------------------------------------------------------------
`default_nettype none
package lsps_pkg;

	localparam int SENSOR_COUNT     = 8;
	localparam int SENSOR_PITCH     = 1000;
	localparam int STEP_INTERVAL_MS = 10;
	localparam int SIDE_BAND        = 250;
	localparam int MS_PER_S         = 1000;
	localparam int CENTER           = (SENSOR_COUNT - 1) / 2;

	localparam int SENS_W  = 12;
	localparam int POS_W   = 15;
	localparam int WPROD_W = SENS_W + 1 + POS_W;
	localparam int WSUM_W  = WPROD_W + 3;
	localparam int SSUM_W  = SENS_W + 3;
	localparam int ERR_W   = 16;
	localparam int DER_W   = 24;
	localparam int DIV_W   = 32;
	localparam int CNT_W   = 6;

	localparam logic [2:0] REG_BLACK_THR = 3'd0;
	localparam logic [2:0] REG_MAX_TURN  = 3'd1;
	localparam logic [2:0] REG_SEARCH    = 3'd2;
	localparam logic [2:0] REG_HARD_ERR  = 3'd3;
	localparam logic [2:0] REG_HARD_SPD  = 3'd4;
	localparam logic [2:0] REG_HARD_FWD  = 3'd5;
	localparam logic [2:0] REG_GAIN_P    = 3'd6;
	localparam logic [2:0] REG_GAIN_D    = 3'd7;

	localparam logic [1:0] MODE_STOP   = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_HARD   = 2'd2;
	localparam logic [1:0] MODE_TRACK  = 2'd3;

	typedef struct packed {
		logic [SENS_W-1:0]         raw;
		logic [SENS_W-1:0]         sig;
		logic signed [WPROD_W-1:0] wprod;
	} lane_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIV_W-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [POS_W-1:0] lane_pos(input int idx);
		int p;
		begin
			p = (idx - CENTER) * SENSOR_PITCH;
			lane_pos = POS_W'(p);
		end
	endfunction

endpackage
`default_nettype wire

### hdl/lsps_ifs.sv
// ----------------------------------------------------------------------------
// lsps channel interfaces
// Sample channel in, steering command channel out; valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface lsps_sample_if import lsps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SENS_W-1:0] sensor_0;
	logic [SENS_W-1:0] sensor_1;
	logic [SENS_W-1:0] sensor_2;
	logic [SENS_W-1:0] sensor_3;
	logic [SENS_W-1:0] sensor_4;
	logic [SENS_W-1:0] sensor_5;
	logic [SENS_W-1:0] sensor_6;
	logic [SENS_W-1:0] sensor_7;
	logic [31:0]       now_ms;
	logic              encoder_ok;
	logic signed [10:0] drive_speed;

	modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
		sensor_5, sensor_6, sensor_7, now_ms, encoder_ok, drive_speed, input ready);
	modport sink (input valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4,
		sensor_5, sensor_6, sensor_7, now_ms, encoder_ok, drive_speed, output ready);
endinterface

interface lsps_command_if import lsps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic signed [10:0]      forward_drive;
	logic signed [10:0]      turn_drive;
	logic signed [ERR_W-1:0] line_error;
	logic                    line_seen;
	logic [SENS_W-1:0]       contrast;

	modport source (output valid, mode, forward_drive, turn_drive, line_error,
		line_seen, contrast, input ready);
	modport sink (input valid, mode, forward_drive, turn_drive, line_error,
		line_seen, contrast, output ready);
endinterface
`default_nettype wire

### hdl/lsps_lane.sv
// ----------------------------------------------------------------------------
// lsps_lane
// One sensor lane: threshold the reading and weight it by lane position.
// ----------------------------------------------------------------------------
`default_nettype none
module lsps_lane import lsps_pkg::*; (
	input  wire logic [SENS_W-1:0]        raw,
	input  wire logic [SENS_W-1:0]        thr,
	input  wire logic signed [POS_W-1:0]  pos,
	output lane_t                         res
);
	logic [SENS_W-1:0] sig;

	assign sig       = (raw > thr) ? (raw - thr) : '0;
	assign res.raw   = raw;
	assign res.sig   = sig;
	assign res.wprod = $signed({1'b0, sig}) * pos;
endmodule
`default_nettype wire

### hdl/lsps_merge.sv
// ----------------------------------------------------------------------------
// lsps_merge
// Combine the lanes: weighted sum, signal sum, max-min contrast, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module lsps_merge import lsps_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       load,
	input  wire lane_t                      lanes [SENSOR_COUNT],
	output logic signed [WSUM_W-1:0]        wsum_q,
	output logic [SSUM_W-1:0]               ssum_q,
	output logic [SENS_W-1:0]               contrast_q
);
	logic signed [WSUM_W-1:0] wsum;
	logic [SSUM_W-1:0]        ssum;
	logic [SENS_W-1:0]        vmin;
	logic [SENS_W-1:0]        vmax;

	always_comb begin
		wsum = '0;
		ssum = '0;
		vmin = '1;
		vmax = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			wsum = wsum + WSUM_W'(lanes[i].wprod);
			ssum = ssum + SSUM_W'(lanes[i].sig);
			if (lanes[i].raw < vmin) vmin = lanes[i].raw;
			if (lanes[i].raw > vmax) vmax = lanes[i].raw;
		end
	end

	// hold the sums until the next sample is loaded
	always_ff @(posedge clk) begin
		if (load) begin
			wsum_q     <= wsum;
			ssum_q     <= ssum;
			contrast_q <= (vmax >= vmin) ? (vmax - vmin) : '0;
		end
	end
endmodule
`default_nettype wire

### hdl/lsps_div.sv
// ----------------------------------------------------------------------------
// lsps_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_sensor_pd_steering_top_defines.svh"
module lsps_div import lsps_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// truncate toward zero: negate the magnitude quotient
	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

	`LSPS_ASSERT_ALWAYS(a_no_restart, clk, arst_n, !(req.start && busy_q))
endmodule
`default_nettype wire

### hdl/line_sensor_pd_steering_top.sv
// Paths: after an input transfer a step ends in stop mode when the encoder is off, in search
// mode when the line is lost, else in hard turn or tracking; the derivative divide runs only
// when a previous error is stored. Samples are taken one at a time: the next transfer can be
// taken in the cycle after the result loads; samples before the interval is up are dropped.
// The shared serial divider computes the centroid and then the derivative, one at a time.
// Reset: arst_n clears control state, step timer, stored error and registers to defaults.
// ----------------------------------------------------------------------------
// line_sensor_pd_steering_top
// Eight-lane line sensor centroid with PD steering, search, hard turn and stop modes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_sensor_pd_steering_top_defines.svh"
module line_sensor_pd_steering_top import lsps_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lsps_sample_if.sink      sample,
	lsps_command_if.source   command,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_SUM   = 4'd2;
	localparam logic [3:0] ST_DIV1  = 4'd3;
	localparam logic [3:0] ST_DER   = 4'd4;
	localparam logic [3:0] ST_DIV2  = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_TURN  = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	// configuration registers
	logic [11:0]        black_thr_q;
	logic [9:0]         max_turn_q;
	logic [9:0]         search_turn_q;
	logic [14:0]        hard_err_q;
	logic [9:0]         hard_spd_q;
	logic signed [10:0] hard_fwd_q;
	logic signed [15:0] gain_p_q;
	logic signed [15:0] gain_d_q;

	// step state
	logic [3:0]              state_q;
	logic                    pv_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic                    side_left_q;
	logic [31:0]             last_time_q;

	// captured sample
	logic [SENS_W-1:0]  sens_q [SENSOR_COUNT];
	logic [31:0]        now_q;
	logic               enc_q;
	logic signed [10:0] speed_q;

	// working values
	logic [31:0]             elapsed_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [DER_W-1:0] deriv_q;
	logic signed [31:0]      pp_s1;
	logic signed [39:0]      pd_s1;

	// result waiting for the output register
	logic [1:0]              r_mode_q;
	logic signed [10:0]      r_fwd_q;
	logic signed [10:0]      r_turn_q;
	logic signed [ERR_W-1:0] r_err_q;
	logic                    r_seen_q;
	logic [SENS_W-1:0]       r_contrast_q;

	// output register
	logic                    out_valid_q;
	logic [1:0]              o_mode_q;
	logic signed [10:0]      o_fwd_q;
	logic signed [10:0]      o_turn_q;
	logic signed [ERR_W-1:0] o_err_q;
	logic                    o_seen_q;
	logic [SENS_W-1:0]       o_contrast_q;

	logic [SENS_W-1:0]        all_sens [8];
	lane_t                    lanes [SENSOR_COUNT];
	logic signed [WSUM_W-1:0] wsum_q;
	logic [SSUM_W-1:0]        ssum_q;
	logic [SENS_W-1:0]        contrast_q;
	div_req_t                 dreq;
	div_rsp_t                 drsp;

	logic               cfg_wr;
	logic [2:0]         cfg_idx;
	logic               in_xfer;
	logic               out_free;
	logic [31:0]        elapsed;
	logic signed [ERR_W-1:0] quo_err;
	logic signed [16:0] diff;
	logic signed [27:0] diff_ms;
	logic [27:0]        diff_mag;
	logic [WSUM_W-1:0]  wsum_mag;
	logic [ERR_W-1:0]   abs_err;
	logic signed [40:0] pd_sum;
	logic signed [40:0] pd_bias;
	logic signed [40:0] turn_raw;
	logic signed [40:0] lim;
	logic signed [10:0] turn_clamped;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = paddr[4:2];
	assign in_xfer  = sample.valid && sample.ready;
	assign out_free = !out_valid_q || command.ready;

	// take a new sample only between steps; a waiting result does not block this
	assign sample.ready = (state_q == ST_IDLE);

	always_comb begin
		unique case (cfg_idx)
			REG_BLACK_THR: prdata = {20'd0, black_thr_q};
			REG_MAX_TURN:  prdata = {22'd0, max_turn_q};
			REG_SEARCH:    prdata = {22'd0, search_turn_q};
			REG_HARD_ERR:  prdata = {17'd0, hard_err_q};
			REG_HARD_SPD:  prdata = {22'd0, hard_spd_q};
			REG_HARD_FWD:  prdata = {{21{hard_fwd_q[10]}}, hard_fwd_q};
			REG_GAIN_P:    prdata = {{16{gain_p_q[15]}}, gain_p_q};
			REG_GAIN_D:    prdata = {{16{gain_d_q[15]}}, gain_d_q};
			default:       prdata = '0;
		endcase
	end

	// lanes: one per sensor, all working on the captured sample together
	assign all_sens = '{sample.sensor_0, sample.sensor_1, sample.sensor_2, sample.sensor_3,
		sample.sensor_4, sample.sensor_5, sample.sensor_6, sample.sensor_7};

	for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
		lsps_lane u_lane (
			.raw (sens_q[g]),
			.thr (black_thr_q),
			.pos (lane_pos(g)),
			.res (lanes[g])
		);
	end

	lsps_merge u_merge (
		.clk        (clk),
		.load       (state_q == ST_CHECK),
		.lanes      (lanes),
		.wsum_q     (wsum_q),
		.ssum_q     (ssum_q),
		.contrast_q (contrast_q)
	);

	// one divider serves the centroid and then the derivative
	assign wsum_mag = wsum_q[WSUM_W-1] ? WSUM_W'(-wsum_q) : WSUM_W'(wsum_q);
	assign diff     = {err_q[ERR_W-1], err_q} - {prev_err_q[ERR_W-1], prev_err_q};
	assign diff_ms  = 28'(diff * $signed(12'(MS_PER_S)));
	assign diff_mag = diff_ms[27] ? 28'(-diff_ms) : 28'(diff_ms);

	always_comb begin
		dreq = '0;
		if (state_q == ST_SUM) begin
			dreq.start = (ssum_q != '0);
			dreq.neg   = wsum_q[WSUM_W-1];
			dreq.num   = DIV_W'(wsum_mag);
			dreq.den   = DIV_W'(ssum_q);
		end else if (state_q == ST_DER) begin
			dreq.start = pv_q;
			dreq.neg   = diff_ms[27];
			dreq.num   = DIV_W'(diff_mag);
			dreq.den   = elapsed_q;
		end
	end

	lsps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign elapsed = now_q - last_time_q;
	assign quo_err = drsp.quo[ERR_W-1:0];
	assign abs_err = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);

	// PD turn: truncate toward zero on the divide by 256, then clamp
	assign pd_sum   = 41'(pp_s1) + 41'(pd_s1);
	assign pd_bias  = pd_sum + (pd_sum[40] ? 41'sd255 : 41'sd0);
	assign turn_raw = pd_bias >>> 8;
	assign lim      = $signed({31'd0, max_turn_q});

	always_comb begin
		priority if (turn_raw > lim) begin
			turn_clamped = $signed({1'b0, max_turn_q});
		end else if (turn_raw < -lim) begin
			turn_clamped = -$signed({1'b0, max_turn_q});
		end else begin
			turn_clamped = turn_raw[10:0];
		end
	end

	// control, configuration and stored step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pv_q          <= 1'b0;
			prev_err_q    <= '0;
			side_left_q   <= 1'b0;
			last_time_q   <= '0;
			out_valid_q   <= 1'b0;
			black_thr_q   <= '0;
			max_turn_q    <= 10'd800;
			search_turn_q <= '0;
			hard_err_q    <= 15'h7FFF;
			hard_spd_q    <= '0;
			hard_fwd_q    <= '0;
			gain_p_q      <= '0;
			gain_d_q      <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_BLACK_THR: black_thr_q   <= pwdata[11:0];
					REG_MAX_TURN:  max_turn_q    <= pwdata[9:0];
					REG_SEARCH:    search_turn_q <= pwdata[9:0];
					REG_HARD_ERR:  hard_err_q    <= pwdata[14:0];
					REG_HARD_SPD:  hard_spd_q    <= pwdata[9:0];
					REG_HARD_FWD:  hard_fwd_q    <= pwdata[10:0];
					REG_GAIN_P: begin
						gain_p_q <= pwdata[15:0];
						pv_q     <= 1'b0;
					end
					REG_GAIN_D: begin
						gain_d_q <= pwdata[15:0];
						pv_q     <= 1'b0;
					end
					default: ;
				endcase
			end

			// load a new result when free, else drop valid once it is taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (command.valid && command.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					priority if (!enc_q) begin
						state_q <= ST_EMIT;
					end else if (elapsed < 32'(STEP_INTERVAL_MS)) begin
						// drop the sample: interval not up
						state_q <= ST_IDLE;
					end else begin
						last_time_q <= now_q;
						state_q     <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (ssum_q == '0) begin
						pv_q    <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (drsp.done) begin
						if (quo_err > $signed(ERR_W'(SIDE_BAND))) side_left_q <= 1'b0;
						if (quo_err < -$signed(ERR_W'(SIDE_BAND))) side_left_q <= 1'b1;
						state_q <= ST_DER;
					end
				end
				ST_DER: begin
					state_q <= pv_q ? ST_DIV2 : ST_MUL;
				end
				ST_DIV2: begin
					if (drsp.done) state_q <= ST_MUL;
				end
				ST_MUL: begin
					prev_err_q <= err_q;
					pv_q       <= 1'b1;
					state_q    <= (abs_err >= {1'b0, hard_err_q}) ? ST_EMIT : ST_TURN;
				end
				ST_TURN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold the result until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < SENSOR_COUNT; i++) sens_q[i] <= all_sens[i];
			now_q   <= sample.now_ms;
			enc_q   <= sample.encoder_ok;
			speed_q <= sample.drive_speed;
		end

		if (state_q == ST_CHECK) begin
			elapsed_q <= elapsed;
			if (!enc_q) begin
				r_mode_q     <= MODE_STOP;
				r_fwd_q      <= '0;
				r_turn_q     <= '0;
				r_err_q      <= prev_err_q;
				r_seen_q     <= 1'b0;
				r_contrast_q <= '0;
			end
		end

		if (state_q == ST_SUM) begin
			r_mode_q     <= MODE_SEARCH;
			r_fwd_q      <= '0;
			r_turn_q     <= side_left_q ? -$signed({1'b0, search_turn_q})
				: $signed({1'b0, search_turn_q});
			r_err_q      <= prev_err_q;
			r_seen_q     <= 1'b0;
			r_contrast_q <= contrast_q;
		end

		if (state_q == ST_DIV1 && drsp.done) err_q <= quo_err;
		if (state_q == ST_DER) deriv_q <= '0;
		if (state_q == ST_DIV2 && drsp.done) deriv_q <= drsp.quo[DER_W-1:0];

		if (state_q == ST_MUL) begin
			pp_s1        <= gain_p_q * err_q;
			pd_s1        <= gain_d_q * deriv_q;
			r_err_q      <= err_q;
			r_seen_q     <= 1'b1;
			r_contrast_q <= contrast_q;
			r_mode_q     <= MODE_HARD;
			r_fwd_q      <= hard_fwd_q;
			r_turn_q     <= err_q[ERR_W-1] ? -$signed({1'b0, hard_spd_q})
				: $signed({1'b0, hard_spd_q});
		end

		if (state_q == ST_TURN) begin
			r_mode_q <= MODE_TRACK;
			r_fwd_q  <= speed_q;
			r_turn_q <= turn_clamped;
		end

		if (state_q == ST_EMIT && out_free) begin
			o_mode_q     <= r_mode_q;
			o_fwd_q      <= r_fwd_q;
			o_turn_q     <= r_turn_q;
			o_err_q      <= r_err_q;
			o_seen_q     <= r_seen_q;
			o_contrast_q <= r_contrast_q;
		end
	end

	assign command.valid         = out_valid_q;
	assign command.mode          = o_mode_q;
	assign command.forward_drive = o_fwd_q;
	assign command.turn_drive    = o_turn_q;
	assign command.line_error    = o_err_q;
	assign command.line_seen     = o_seen_q;
	assign command.contrast      = o_contrast_q;

	`LSPS_ASSERT_NEXT(a_emit_holds, clk, arst_n,
		state_q == ST_EMIT && out_valid_q && !command.ready, state_q == ST_EMIT)
	`LSPS_ASSERT_ALWAYS(a_seen_mode, clk, arst_n,
		!out_valid_q || (o_seen_q == (o_mode_q == MODE_HARD || o_mode_q == MODE_TRACK)))
	`LSPS_ASSERT_NEXT(a_err_stored, clk, arst_n, state_q == ST_MUL, pv_q && prev_err_q == err_q)
endmodule
`default_nettype wire
